// ===== design/ple_pkg.sv =====
package ple_pkg;

    // Default list capacity.
    localparam int CAPACITY_DEF = 16;

    // Field widths of the request and result ports.
    localparam int REQ_W    = 3;
    localparam int POS_W    = 5;
    localparam int VAL_W    = 32;
    localparam int FOUND_W  = 4;
    localparam int STATUS_W = 2;
    localparam int LEN_W    = 5;

    // Request codes.
    localparam logic [REQ_W-1:0] REQ_INSERT   = 3'd0;
    localparam logic [REQ_W-1:0] REQ_APPEND   = 3'd1;
    localparam logic [REQ_W-1:0] REQ_REMOVE   = 3'd2;
    localparam logic [REQ_W-1:0] REQ_REM_TAIL = 3'd3;
    localparam logic [REQ_W-1:0] REQ_SEARCH   = 3'd4;
    localparam logic [REQ_W-1:0] REQ_READ     = 3'd5;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STS_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] STS_BAD  = 2'd1;
    localparam logic [STATUS_W-1:0] STS_FULL = 2'd2;
    localparam logic [STATUS_W-1:0] STS_MISS = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_INS_RD,
        S_INS_WR,
        S_REM_CAP,
        S_REM_RD,
        S_REM_WR,
        S_SRCH_RD,
        S_SRCH_CMP,
        S_RD_CAP,
        S_FIN
    } state_t;

    typedef enum logic [2:0] {
        IDX_HOLD,
        IDX_CNT,
        IDX_POS,
        IDX_ZERO,
        IDX_INC,
        IDX_DEC
    } idx_op_t;

    typedef enum logic [1:0] {
        RA_POS,
        RA_IDX,
        RA_PREV,
        RA_NEXT
    } raddr_sel_t;

    typedef enum logic [2:0] {
        RES_HOLD,
        RES_CLEAR,
        RES_BAD,
        RES_FULL,
        RES_MISS,
        RES_OK,
        RES_FOUND,
        RES_DATA
    } res_op_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       load;
        idx_op_t    idx_op;
        raddr_sel_t ra;
        logic       we;
        logic       wr_val;
        logic       cnt_inc;
        logic       cnt_dec;
        res_op_t    res_op;
        logic       emit;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [REQ_W-1:0] req;
        logic             pos_le_cnt;
        logic             pos_lt_cnt;
        logic             full;
        logic             idx_gt_pos;
        logic             idx1_lt_cnt;
        logic             idx_lt_cnt;
        logic             match;
        logic             out_free;
    } stat_t;

endpackage

// ===== design/ple_ram.sv =====
module ple_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== design/ple_ctrl.sv =====
module ple_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    input  ple_pkg::stat_t stat,
    output ple_pkg::cmd_t  cmd
);

    import ple_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (stat.req inside {REQ_INSERT, REQ_APPEND})
                begin
                    state_next = (stat.pos_le_cnt && !stat.full) ? S_INS_RD : S_FIN;
                end
                else if (stat.req inside {REQ_REMOVE, REQ_REM_TAIL})
                begin
                    state_next = stat.pos_lt_cnt ? S_REM_CAP : S_FIN;
                end
                else if (stat.req == REQ_SEARCH)
                begin
                    state_next = S_SRCH_RD;
                end
                else if (stat.req == REQ_READ)
                begin
                    state_next = stat.pos_lt_cnt ? S_RD_CAP : S_FIN;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_INS_RD:   state_next = stat.idx_gt_pos ? S_INS_WR : S_FIN;
            S_INS_WR:   state_next = S_INS_RD;
            S_REM_CAP:  state_next = S_REM_RD;
            S_REM_RD:   state_next = stat.idx1_lt_cnt ? S_REM_WR : S_FIN;
            S_REM_WR:   state_next = S_REM_RD;
            S_SRCH_RD:  state_next = stat.idx_lt_cnt ? S_SRCH_CMP : S_FIN;
            S_SRCH_CMP: state_next = stat.match ? S_FIN : S_SRCH_RD;
            S_RD_CAP:   state_next = S_FIN;
            S_FIN:
            begin
                if (stat.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:    state_next = S_IDLE;
        endcase
    end

    // Outputs.
    always_comb
    begin
        in_stall    = 1'b1;
        cmd.load    = 1'b0;
        cmd.idx_op  = IDX_HOLD;
        cmd.ra      = RA_IDX;
        cmd.we      = 1'b0;
        cmd.wr_val  = 1'b0;
        cmd.cnt_inc = 1'b0;
        cmd.cnt_dec = 1'b0;
        cmd.res_op  = RES_HOLD;
        cmd.emit    = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    cmd.idx_op = IDX_CNT;
                    cmd.res_op = RES_CLEAR;
                end
            end
            S_DECODE:
            begin
                if (stat.req inside {REQ_INSERT, REQ_APPEND})
                begin
                    if (!stat.pos_le_cnt)
                    begin
                        cmd.res_op = RES_BAD;
                    end
                    else if (stat.full)
                    begin
                        cmd.res_op = RES_FULL;
                    end
                end
                else if (stat.req inside {REQ_REMOVE, REQ_REM_TAIL})
                begin
                    if (stat.pos_lt_cnt)
                    begin
                        cmd.idx_op = IDX_POS;
                        cmd.ra     = RA_POS;
                    end
                    else
                    begin
                        cmd.res_op = RES_BAD;
                    end
                end
                else if (stat.req == REQ_SEARCH)
                begin
                    cmd.idx_op = IDX_ZERO;
                end
                else if (stat.req == REQ_READ)
                begin
                    if (stat.pos_lt_cnt)
                    begin
                        cmd.ra = RA_POS;
                    end
                    else
                    begin
                        cmd.res_op = RES_BAD;
                    end
                end
                else
                begin
                    cmd.res_op = RES_BAD;
                end
            end
            S_INS_RD:
            begin
                if (stat.idx_gt_pos)
                begin
                    cmd.ra = RA_PREV;
                end
                else
                begin
                    cmd.we      = 1'b1;
                    cmd.wr_val  = 1'b1;
                    cmd.cnt_inc = 1'b1;
                    cmd.res_op  = RES_OK;
                end
            end
            S_INS_WR:
            begin
                cmd.we     = 1'b1;
                cmd.idx_op = IDX_DEC;
            end
            S_REM_CAP:
            begin
                cmd.res_op = RES_DATA;
            end
            S_REM_RD:
            begin
                if (stat.idx1_lt_cnt)
                begin
                    cmd.ra = RA_NEXT;
                end
                else
                begin
                    cmd.cnt_dec = 1'b1;
                end
            end
            S_REM_WR:
            begin
                cmd.we     = 1'b1;
                cmd.idx_op = IDX_INC;
            end
            S_SRCH_RD:
            begin
                if (stat.idx_lt_cnt)
                begin
                    cmd.ra = RA_IDX;
                end
                else
                begin
                    cmd.res_op = RES_MISS;
                end
            end
            S_SRCH_CMP:
            begin
                if (stat.match)
                begin
                    cmd.res_op = RES_FOUND;
                end
                else
                begin
                    cmd.idx_op = IDX_INC;
                end
            end
            S_RD_CAP:
            begin
                cmd.res_op = RES_DATA;
            end
            S_FIN:
            begin
                cmd.emit = stat.out_free;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    // The entry store is only written while entries are being moved or placed.
    a_write_states: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.we |-> (state_reg == S_INS_RD || state_reg == S_INS_WR ||
                    state_reg == S_REM_WR))
        else $error("entry write outside insert or remove");

    // An accepted request is always decoded in the following cycle.
    a_accept_decode: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg == S_DECODE))
        else $error("accepted request not decoded");

    // A result is never pushed into an occupied, stalled output register.
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> stat.out_free)
        else $error("result emitted while output busy");

endmodule

// ===== design/ple_datapath.sv =====
module ple_datapath #(
    parameter int CAPACITY = ple_pkg::CAPACITY_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  ple_pkg::cmd_t                     cmd,
    output ple_pkg::stat_t                    stat,
    input  logic [ple_pkg::REQ_W-1:0]         req_type,
    input  logic [ple_pkg::POS_W-1:0]         position,
    input  logic signed [ple_pkg::VAL_W-1:0]  value,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [ple_pkg::VAL_W-1:0]  data,
    output logic [ple_pkg::FOUND_W-1:0]       found_index,
    output logic [ple_pkg::STATUS_W-1:0]      status,
    output logic [ple_pkg::LEN_W-1:0]         length,
    output logic                              is_empty
);

    import ple_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = (CW > POS_W) ? CW : POS_W;

    logic [CW-1:0]       count_reg;
    logic [CW-1:0]       count_next;
    logic [CW-1:0]       idx_reg;
    logic [CW-1:0]       idx_next;
    logic [REQ_W-1:0]    req_reg;
    logic [XW-1:0]       pos_reg;
    logic [VAL_W-1:0]    val_reg;
    logic [VAL_W-1:0]    res_data_reg;
    logic [FOUND_W-1:0]  res_found_reg;
    logic [STATUS_W-1:0] res_status_reg;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic [VAL_W-1:0]    out_data_reg;
    logic [FOUND_W-1:0]  out_found_reg;
    logic [STATUS_W-1:0] out_status_reg;
    logic [CW-1:0]       out_count_reg;

    logic [XW-1:0]       cnt_ext;
    logic [XW-1:0]       idx_ext;
    logic [XW-1:0]       idx_plus1;
    logic [XW-1:0]       pos_load;
    logic [XW-1:0]       raddr_ext;
    logic [VAL_W-1:0]    rdata;
    logic [VAL_W-1:0]    wdata;

    assign cnt_ext   = XW'(count_reg);
    assign idx_ext   = XW'(idx_reg);
    assign idx_plus1 = idx_ext + XW'(1);

    // Append targets the tail; removing the tail of an empty list wraps to
    // an out-of-range position and so fails the range check.
    always_comb
    begin
        case (req_type)
            REQ_APPEND:   pos_load = cnt_ext;
            REQ_REM_TAIL: pos_load = cnt_ext - XW'(1);
            default:      pos_load = XW'(position);
        endcase
    end

    always_comb
    begin
        case (cmd.ra)
            RA_POS:  raddr_ext = pos_reg;
            RA_IDX:  raddr_ext = idx_ext;
            RA_PREV: raddr_ext = idx_ext - XW'(1);
            RA_NEXT: raddr_ext = idx_plus1;
            default: raddr_ext = idx_ext;
        endcase
    end

    assign wdata = cmd.wr_val ? val_reg : rdata;

    ple_ram #(
        .WIDTH (VAL_W),
        .DEPTH (CAPACITY)
    ) u_entries (
        .clk   (clk),
        .we    (cmd.we),
        .waddr (idx_ext[AW-1:0]),
        .wdata (wdata),
        .raddr (raddr_ext[AW-1:0]),
        .rdata (rdata)
    );

    always_comb
    begin
        count_next = count_reg;
        if (cmd.cnt_inc)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (cmd.cnt_dec)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_comb
    begin
        case (cmd.idx_op)
            IDX_CNT:  idx_next = count_reg;
            IDX_POS:  idx_next = pos_reg[CW-1:0];
            IDX_ZERO: idx_next = '0;
            IDX_INC:  idx_next = idx_reg + CW'(1);
            IDX_DEC:  idx_next = idx_reg - CW'(1);
            default:  idx_next = idx_reg;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        if (cmd.load)
        begin
            req_reg <= req_type;
            pos_reg <= pos_load;
            val_reg <= value;
        end
        case (cmd.res_op)
            RES_CLEAR:
            begin
                res_data_reg   <= '0;
                res_found_reg  <= '0;
                res_status_reg <= STS_BAD;
            end
            RES_BAD:   res_status_reg <= STS_BAD;
            RES_FULL:  res_status_reg <= STS_FULL;
            RES_MISS:  res_status_reg <= STS_MISS;
            RES_OK:    res_status_reg <= STS_OK;
            RES_FOUND:
            begin
                res_found_reg  <= idx_ext[FOUND_W-1:0];
                res_status_reg <= STS_OK;
            end
            RES_DATA:
            begin
                res_data_reg   <= rdata;
                res_status_reg <= STS_OK;
            end
            default:
            begin
                res_status_reg <= res_status_reg;
            end
        endcase
        if (cmd.emit)
        begin
            out_data_reg   <= res_data_reg;
            out_found_reg  <= res_found_reg;
            out_status_reg <= res_status_reg;
            out_count_reg  <= count_reg;
        end
    end

    assign stat.req         = req_reg;
    assign stat.pos_le_cnt  = (pos_reg <= cnt_ext);
    assign stat.pos_lt_cnt  = (pos_reg < cnt_ext);
    assign stat.full        = (cnt_ext >= XW'(CAPACITY));
    assign stat.idx_gt_pos  = (idx_ext > pos_reg);
    assign stat.idx1_lt_cnt = (idx_plus1 < cnt_ext);
    assign stat.idx_lt_cnt  = (idx_ext < cnt_ext);
    assign stat.match       = (rdata == val_reg);
    assign stat.out_free    = !out_valid_reg || !out_stall;

    logic [XW-1:0] out_count_ext;
    assign out_count_ext = XW'(out_count_reg);

    assign out_valid   = out_valid_reg;
    assign data        = out_data_reg;
    assign found_index = out_found_reg;
    assign status      = out_status_reg;
    assign length      = out_count_ext[LEN_W-1:0];
    assign is_empty    = (out_count_reg == '0);

    // The fill level never exceeds the capacity.
    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("list length above capacity");

    // The fill level moves by at most one entry per request.
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |->
            (count_reg == $past(count_reg) + CW'(1) ||
             count_reg == $past(count_reg) - CW'(1)))
        else $error("list length jumped");

    // An insert never grows a full list.
    a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.cnt_inc |-> (count_reg < CW'(CAPACITY)))
        else $error("insert into full list");

endmodule

// ===== design/positional_list_engine.sv =====
// Ordered list of up to CAPACITY signed 32-bit values with positional insert
// and remove, tail append and remove, first-match search and indexed read.
// Each request returns exactly one result carrying the removed or read value,
// the matching position of a search, a status code (ok, bad position or
// empty, full, not found) and the length and emptiness after the request; a
// failed request leaves the list unchanged. Entries live in a single-port-
// write RAM with a registered read, and the controller moves one entry per
// pass through a read state and a write state, so latency depends on the
// request and the current length. A finished result also waits while the
// output register is still held by out_stall. One request is worked on at a
// time; the next is accepted as soon as the result has been loaded into the
// output register, even while that result still waits behind out_stall. No
// clearing pass is needed after reset.
module positional_list_engine #(
    parameter int CAPACITY = ple_pkg::CAPACITY_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [ple_pkg::REQ_W-1:0]         req_type,
    input  logic [ple_pkg::POS_W-1:0]         position,
    input  logic signed [ple_pkg::VAL_W-1:0]  value,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [ple_pkg::VAL_W-1:0]  data,
    output logic [ple_pkg::FOUND_W-1:0]       found_index,
    output logic [ple_pkg::STATUS_W-1:0]      status,
    output logic [ple_pkg::LEN_W-1:0]         length,
    output logic                              is_empty
);

    import ple_pkg::*;

    // Command and status links between the sequencer and the datapath.
    cmd_t  cmd;
    stat_t stat;

    // The controller walks each request through decode, the entry moves, the
    // search scan or the read capture, and the hand-off of the result.
    ple_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    // The datapath holds the entry RAM, the length and loop index, the
    // captured request, the pending result and the output register.
    ple_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .req_type    (req_type),
        .position    (position),
        .value       (value),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .data        (data),
        .found_index (found_index),
        .status      (status),
        .length      (length),
        .is_empty    (is_empty)
    );

endmodule
